### rtl/qpg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the quaternion projection gradient unit.
// Used by every module of the block; depends on nothing else.
package qpg_pkg;

    localparam int QUAT_W     = 16;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int DEF_QUAT_FRAC_BITS = 14;
    localparam int FIFO_DEPTH = 4;

    // Internal word sizes, set by the worst-case magnitudes of the products.
    localparam int PROD_W = 48;   // quaternion component times coordinate
    localparam int SQ_W   = 63;   // cam_z squared, unsigned
    localparam int DW     = 51;   // derivative component
    localparam int D_LO_W = 26;   // low split of a derivative component
    localparam int PP1_W  = 59;   // partial product coordinate times derivative split
    localparam int EW     = 83;   // cross term z*d - c*dz
    localparam int E_CH_W = 28;   // split size of a cross term
    localparam int PP2_W  = 61;   // partial product weight times cross-term split
    localparam int NW     = 115;  // signed numerator
    localparam int MAGW   = 114;  // numerator magnitude
    localparam int QBITS  = 33;   // quotient bits resolved by the divider

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X = 8'd0,
        REG_QUAT_Y = 8'd1,
        REG_QUAT_Z = 8'd2,
        REG_QUAT_W = 8'd3
    } t_cfg_reg;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [QUAT_W-1:0]  t_quat;

    typedef struct packed {
        t_coord model_x;
        t_coord model_y;
        t_coord model_z;
        t_coord cam_x;
        t_coord cam_y;
        t_coord cam_z;
        t_coord weight_x;
        t_coord weight_y;
    } t_pixel;

    typedef struct packed {
        t_pixel pix;
        logic   zero;
    } t_item;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

    typedef struct packed {
        logic [MAGW-1:0] mag;
        logic            res_neg;
        logic            pre_sat;
    } t_quot_req;

endpackage

### rtl/qpg_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixel beats, flags zero depth and queues them for the back end.
// Depends on qpg_pkg.
module qpg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qpg_pkg::t_pixel i_pix,
    output logic            o_valid,
    input  logic            i_pop,
    output qpg_pkg::t_item  o_item
);

    localparam int AW = (qpg_pkg::FIFO_DEPTH > 1) ? $clog2(qpg_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(qpg_pkg::FIFO_DEPTH + 1);

    qpg_pkg::t_item r_mem [qpg_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;
    qpg_pkg::t_item w_item;

    assign o_ready = (r_count != CW'(qpg_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid & o_ready;
    assign w_pop   = i_pop & o_valid;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        w_item.pix  = i_pix;
        w_item.zero = (i_pix.cam_z == '0);
        n_wr = r_wr;
        n_rd = r_rd;
        if (w_push) begin
            n_wr = (r_wr == AW'(qpg_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(qpg_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(qpg_pkg::FIFO_DEPTH))
        else $error("queue fill count exceeds its depth");

endmodule

### rtl/qpg_back.sv
`timescale 1ns / 1ps
// Back end arithmetic: rotation derivatives, projection chain and numerator magnitude.
// Seven register stages that advance together; depends on qpg_pkg.
module qpg_back #(
    parameter int QUAT_FRAC_BITS = qpg_pkg::DEF_QUAT_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  qpg_pkg::t_item                       i_item,
    input  qpg_pkg::t_quat                       i_quat [4],
    output qpg_pkg::t_ctl                        o_ctl,
    output qpg_pkg::t_quot_req                   o_req [4],
    output logic [qpg_pkg::SQ_W+QUAT_FRAC_BITS-1:0] o_den
);

    localparam int DENW = qpg_pkg::SQ_W + QUAT_FRAC_BITS;
    localparam int NST  = 7;
    localparam int HW   = (qpg_pkg::MAGW - qpg_pkg::QBITS > DENW) ?
                          (qpg_pkg::MAGW - qpg_pkg::QBITS) : DENW;

    typedef logic signed [qpg_pkg::PROD_W-1:0] t_prod;
    typedef logic signed [qpg_pkg::DW-1:0]     t_d;

    function automatic t_d x2(input t_prod p);
        return t_d'(p) <<< 1;
    endfunction

    function automatic t_d x4(input t_prod p);
        return t_d'(p) <<< 2;
    endfunction

    qpg_pkg::t_ctl r_ctl [NST];

    // stage 1
    t_prod                       r_prod [4][3];
    logic [qpg_pkg::SQ_W-1:0]    r_sq;
    qpg_pkg::t_pixel             r_pix1;
    // stage 2
    t_d                          r_d [4][3];
    qpg_pkg::t_pixel             r_pix2;
    // stage 3
    logic signed [qpg_pkg::PP1_W-1:0] r_pl [4][4];
    logic signed [qpg_pkg::PP1_W-1:0] r_ph [4][4];
    qpg_pkg::t_coord             r_w3 [2];
    // stage 4
    logic signed [qpg_pkg::EW-1:0] r_e [4][2];
    qpg_pkg::t_coord             r_w4 [2];
    // stage 5
    logic signed [qpg_pkg::PP2_W-1:0] r_pp [4][2][3];
    // stage 6
    logic signed [qpg_pkg::NW-1:0] r_num [4];
    // stage 7
    qpg_pkg::t_quot_req          r_req [4];
    // divisor travels from stage 2 to stage 7
    logic [DENW-1:0]             r_den [NST-1];

    qpg_pkg::t_coord             w_m [3];
    logic signed [63:0]          w_sq64;
    t_d                          w_d [4][3];
    qpg_pkg::t_coord             w_c [4][4];
    t_d                          w_dop [4][4];
    logic signed [qpg_pkg::EW-1:0] w_full [4][4];
    logic signed [qpg_pkg::NW-1:0] w_sum [4];
    logic signed [qpg_pkg::NW-1:0] w_neg [4];
    logic [qpg_pkg::MAGW-1:0]    w_mag [4];

    always_comb begin
        w_m[0] = i_item.pix.model_x;
        w_m[1] = i_item.pix.model_y;
        w_m[2] = i_item.pix.model_z;
        w_sq64 = 64'(i_item.pix.cam_z) * 64'(i_item.pix.cam_z);
    end

    // Partial derivatives of R(q)m, products indexed [quat component][model axis].
    always_comb begin
        w_d[0][0] = x2(r_prod[1][1]) + x2(r_prod[2][2]);
        w_d[0][1] = x2(r_prod[1][0]) - x4(r_prod[0][1]) - x2(r_prod[3][2]);
        w_d[0][2] = x2(r_prod[2][0]) + x2(r_prod[3][1]) - x4(r_prod[0][2]);
        w_d[1][0] = x2(r_prod[0][1]) - x4(r_prod[1][0]) + x2(r_prod[3][2]);
        w_d[1][1] = x2(r_prod[0][0]) + x2(r_prod[2][2]);
        w_d[1][2] = x2(r_prod[2][1]) - x2(r_prod[3][0]) - x4(r_prod[1][2]);
        w_d[2][0] = x2(r_prod[0][2]) - x2(r_prod[3][1]) - x4(r_prod[2][0]);
        w_d[2][1] = x2(r_prod[3][0]) - x4(r_prod[2][1]) + x2(r_prod[1][2]);
        w_d[2][2] = x2(r_prod[0][0]) + x2(r_prod[1][1]);
        w_d[3][0] = x2(r_prod[1][2]) - x2(r_prod[2][1]);
        w_d[3][1] = x2(r_prod[2][0]) - x2(r_prod[0][2]);
        w_d[3][2] = x2(r_prod[0][1]) - x2(r_prod[1][0]);
    end

    // Operand pairs of the cross terms: z*dx, x*dz, z*dy, y*dz.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_c[k][0]   = r_pix2.cam_z;
            w_c[k][1]   = r_pix2.cam_x;
            w_c[k][2]   = r_pix2.cam_z;
            w_c[k][3]   = r_pix2.cam_y;
            w_dop[k][0] = r_d[k][0];
            w_dop[k][1] = r_d[k][2];
            w_dop[k][2] = r_d[k][1];
            w_dop[k][3] = r_d[k][2];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int t = 0; t < 4; t++) begin
                w_full[k][t] = (qpg_pkg::EW'(r_ph[k][t]) <<< qpg_pkg::D_LO_W)
                             + qpg_pkg::EW'(r_pl[k][t]);
            end
            w_sum[k] = '0;
            for (int s = 0; s < 2; s++) begin
                w_sum[k] = w_sum[k] + qpg_pkg::NW'(r_pp[k][s][0])
                         + (qpg_pkg::NW'(r_pp[k][s][1]) <<< qpg_pkg::E_CH_W)
                         + (qpg_pkg::NW'(r_pp[k][s][2]) <<< (2 * qpg_pkg::E_CH_W));
            end
            w_neg[k] = -r_num[k];
            w_mag[k] = r_num[k][qpg_pkg::NW-1] ? w_neg[k][qpg_pkg::MAGW-1:0]
                                               : r_num[k][qpg_pkg::MAGW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (i_adv) begin
            r_ctl[0].valid <= i_valid;
            r_ctl[0].zero  <= i_item.zero;
            for (int i = 1; i < NST; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= t_prod'(i_quat[i]) * t_prod'(w_m[j]);
                end
            end
            r_sq   <= w_sq64[qpg_pkg::SQ_W-1:0];
            r_pix1 <= i_item.pix;

            r_d    <= w_d;
            r_pix2 <= r_pix1;
            r_den[0] <= DENW'(r_sq) << QUAT_FRAC_BITS;
            for (int i = 1; i < NST - 1; i++) begin
                r_den[i] <= r_den[i-1];
            end

            for (int k = 0; k < 4; k++) begin
                for (int t = 0; t < 4; t++) begin
                    r_pl[k][t] <= qpg_pkg::PP1_W'(w_c[k][t])
                        * qpg_pkg::PP1_W'($signed({1'b0, w_dop[k][t][qpg_pkg::D_LO_W-1:0]}));
                    r_ph[k][t] <= qpg_pkg::PP1_W'(w_c[k][t])
                        * qpg_pkg::PP1_W'($signed(w_dop[k][t][qpg_pkg::DW-1:qpg_pkg::D_LO_W]));
                end
            end
            r_w3[0] <= r_pix2.weight_x;
            r_w3[1] <= r_pix2.weight_y;

            for (int k = 0; k < 4; k++) begin
                r_e[k][0] <= w_full[k][0] - w_full[k][1];
                r_e[k][1] <= w_full[k][2] - w_full[k][3];
            end
            r_w4 <= r_w3;

            for (int k = 0; k < 4; k++) begin
                for (int s = 0; s < 2; s++) begin
                    r_pp[k][s][0] <= qpg_pkg::PP2_W'(r_w4[s])
                        * qpg_pkg::PP2_W'($signed({1'b0, r_e[k][s][qpg_pkg::E_CH_W-1:0]}));
                    r_pp[k][s][1] <= qpg_pkg::PP2_W'(r_w4[s])
                        * qpg_pkg::PP2_W'($signed({1'b0,
                            r_e[k][s][2*qpg_pkg::E_CH_W-1:qpg_pkg::E_CH_W]}));
                    r_pp[k][s][2] <= qpg_pkg::PP2_W'(r_w4[s])
                        * qpg_pkg::PP2_W'($signed(r_e[k][s][qpg_pkg::EW-1:2*qpg_pkg::E_CH_W]));
                end
            end

            r_num <= w_sum;

            // The quotient overflows 33 bits exactly when floor(mag / 2^33) >= den.
            for (int k = 0; k < 4; k++) begin
                r_req[k].mag     <= w_mag[k];
                r_req[k].res_neg <= !r_num[k][qpg_pkg::NW-1];
                r_req[k].pre_sat <= HW'(w_mag[k][qpg_pkg::MAGW-1:qpg_pkg::QBITS])
                                    >= HW'(r_den[NST-3]);
            end
        end
    end

    assign o_ctl = r_ctl[NST-1];
    assign o_req = r_req;
    assign o_den = r_den[NST-2];

endmodule

### rtl/qpg_div.sv
`timescale 1ns / 1ps
// One divider lane: restoring division, one quotient bit per stage, then saturation.
// Depends on qpg_pkg; the stages advance with the back end.
module qpg_div #(
    parameter int QUAT_FRAC_BITS = qpg_pkg::DEF_QUAT_FRAC_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_adv,
    input  qpg_pkg::t_quot_req                      i_req,
    input  logic [qpg_pkg::SQ_W+QUAT_FRAC_BITS-1:0] i_den,
    output logic signed [31:0]                      o_grad,
    output logic                                    o_sat
);

    localparam int DENW = qpg_pkg::SQ_W + QUAT_FRAC_BITS;
    localparam int QB   = qpg_pkg::QBITS;
    localparam int MW   = qpg_pkg::MAGW;
    localparam int CMPW = ((MW > DENW + QB - 1) ? MW : (DENW + QB - 1)) + 1;

    logic [MW-1:0]   r_rem [QB];
    logic [QB-1:0]   r_q   [QB];
    logic [DENW-1:0] r_den [QB];
    logic            r_neg [QB];
    logic            r_ps  [QB];
    logic signed [31:0] r_grad;
    logic            r_sat;

    logic [MW-1:0]   w_rem_in [QB];
    logic [QB-1:0]   w_q_in   [QB];
    logic [DENW-1:0] w_den_in [QB];
    logic            w_neg_in [QB];
    logic            w_ps_in  [QB];
    logic [CMPW-1:0] w_trial  [QB];
    logic            w_ge     [QB];
    logic [QB-1:0]   w_q;
    logic            w_over;
    logic [31:0]     w_mag32;

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            if (s == 0) begin
                w_rem_in[s] = i_req.mag;
                w_q_in[s]   = '0;
                w_den_in[s] = i_den;
                w_neg_in[s] = i_req.res_neg;
                w_ps_in[s]  = i_req.pre_sat;
            end else begin
                w_rem_in[s] = r_rem[s-1];
                w_q_in[s]   = r_q[s-1];
                w_den_in[s] = r_den[s-1];
                w_neg_in[s] = r_neg[s-1];
                w_ps_in[s]  = r_ps[s-1];
            end
            w_trial[s] = CMPW'(w_rem_in[s]) - (CMPW'(w_den_in[s]) << (QB - 1 - s));
            w_ge[s]    = !w_trial[s][CMPW-1];
        end
    end

    // A negative result may reach 2^31, a positive one only 2^31 - 1.
    always_comb begin
        w_q    = r_q[QB-1];
        w_over = r_ps[QB-1] ||
                 (r_neg[QB-1] ? (w_q > QB'(qpg_pkg::SAT_NEG)) : (w_q > QB'(qpg_pkg::SAT_POS)));
        if (w_over) begin
            w_mag32 = r_neg[QB-1] ? qpg_pkg::SAT_NEG : qpg_pkg::SAT_POS;
        end else begin
            w_mag32 = w_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < QB; s++) begin
                r_rem[s] <= w_ge[s] ? w_trial[s][MW-1:0] : w_rem_in[s];
                r_q[s]   <= w_q_in[s] | (QB'(w_ge[s]) << (QB - 1 - s));
                r_den[s] <= w_den_in[s];
                r_neg[s] <= w_neg_in[s];
                r_ps[s]  <= w_ps_in[s];
            end
            r_grad <= r_neg[QB-1] ? -$signed(w_mag32) : $signed(w_mag32);
            r_sat  <= w_over;
        end
    end

    assign o_grad = r_grad;
    assign o_sat  = r_sat;

endmodule

### rtl/quaternion_projection_gradient_unit.sv
`timescale 1ns / 1ps
// Top level of the quaternion projection gradient unit: config registers,
// front queue, arithmetic back end and four divider lanes. Depends on qpg_pkg.

// The unit takes one pixel beat per clock and returns one result beat per clock
// while the output is not stalled: a beat waits in the four-entry input queue,
// then passes through the derivative and projection stages of the back end and
// the divider lanes, which resolve one quotient bit per stage (33 bits) plus a
// saturation stage. The whole back end stalls together while a result beat
// waits at the output, and the queue keeps taking beats until full.
// The quaternion registers are written through the configuration channel, which
// is always ready; writes to an index above 3 are dropped and the data word is 16
// bits wide. Write them only while no pixel is in flight.
module quaternion_projection_gradient_unit #(
    parameter int QUAT_FRAC_BITS = qpg_pkg::DEF_QUAT_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qpg_pkg::QUAT_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [31:0]              i_model_x,
    input  logic signed [31:0]              i_model_y,
    input  logic signed [31:0]              i_model_z,
    input  logic signed [31:0]              i_cam_x,
    input  logic signed [31:0]              i_cam_y,
    input  logic signed [31:0]              i_cam_z,
    input  logic signed [31:0]              i_weight_x,
    input  logic signed [31:0]              i_weight_y,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_grad_qx,
    output logic signed [31:0]              o_grad_qy,
    output logic signed [31:0]              o_grad_qz,
    output logic signed [31:0]              o_grad_qw,
    output logic                            o_depth_zero,
    output logic                            o_saturated
);

    localparam int DENW = qpg_pkg::SQ_W + QUAT_FRAC_BITS;
    localparam int LAT  = qpg_pkg::QBITS + 1;
    localparam logic [qpg_pkg::QUAT_W-1:0] QUAT_ONE =
        qpg_pkg::QUAT_W'(32'd1 << QUAT_FRAC_BITS);

    qpg_pkg::t_quat     r_quat [4];
    qpg_pkg::t_ctl      r_ctl [LAT];
    qpg_pkg::t_pixel    w_pix;
    qpg_pkg::t_item     w_item;
    qpg_pkg::t_ctl      w_back_ctl;
    qpg_pkg::t_quot_req w_req [4];
    logic [DENW-1:0]    w_den;
    logic               w_fq_valid;
    logic               w_adv;
    logic               w_pop;
    logic signed [31:0] w_grad [4];
    logic               w_sat [4];
    logic               w_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= '0;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= QUAT_ONE;
        end else if (i_cfg_valid) begin
            unique case (qpg_pkg::t_cfg_reg'(i_cfg_index))
                qpg_pkg::REG_QUAT_X: r_quat[0] <= i_cfg_data;
                qpg_pkg::REG_QUAT_Y: r_quat[1] <= i_cfg_data;
                qpg_pkg::REG_QUAT_Z: r_quat[2] <= i_cfg_data;
                qpg_pkg::REG_QUAT_W: r_quat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_pix.model_x  = i_model_x;
        w_pix.model_y  = i_model_y;
        w_pix.model_z  = i_model_z;
        w_pix.cam_x    = i_cam_x;
        w_pix.cam_y    = i_cam_y;
        w_pix.cam_z    = i_cam_z;
        w_pix.weight_x = i_weight_x;
        w_pix.weight_y = i_weight_y;
    end

    // The back end moves whenever the output slot is empty or being drained.
    assign w_adv = !r_ctl[LAT-1].valid || i_out_ready;
    assign w_pop = w_adv && w_fq_valid;

    qpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_pix   (w_pix),
        .o_valid (w_fq_valid),
        .i_pop   (w_pop),
        .o_item  (w_item)
    );

    qpg_back #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pop),
        .i_item  (w_item),
        .i_quat  (r_quat),
        .o_ctl   (w_back_ctl),
        .o_req   (w_req),
        .o_den   (w_den)
    );

    for (genvar k = 0; k < 4; k++) begin : g_lane
        qpg_div #(
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_req  (w_req[k]),
            .i_den  (w_den),
            .o_grad (w_grad[k]),
            .o_sat  (w_sat[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (w_adv) begin
            r_ctl[0] <= w_back_ctl;
            for (int i = 1; i < LAT; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign w_zero       = r_ctl[LAT-1].zero;
    assign o_out_valid  = r_ctl[LAT-1].valid;
    assign o_depth_zero = w_zero;
    assign o_grad_qx    = w_zero ? '0 : w_grad[0];
    assign o_grad_qy    = w_zero ? '0 : w_grad[1];
    assign o_grad_qz    = w_zero ? '0 : w_grad[2];
    assign o_grad_qw    = w_zero ? '0 : w_grad[3];
    assign o_saturated  = !w_zero && (w_sat[0] || w_sat[1] || w_sat[2] || w_sat[3]);

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_depth_zero) |-> (o_grad_qx == '0 && o_grad_qy == '0 &&
            o_grad_qz == '0 && o_grad_qw == '0 && !o_saturated))
        else $error("zero-depth beat carries nonzero gradients or a saturation flag");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_grad_qx == qpg_pkg::SAT_POS || o_grad_qx == qpg_pkg::SAT_NEG ||
             o_grad_qy == qpg_pkg::SAT_POS || o_grad_qy == qpg_pkg::SAT_NEG ||
             o_grad_qz == qpg_pkg::SAT_POS || o_grad_qz == qpg_pkg::SAT_NEG ||
             o_grad_qw == qpg_pkg::SAT_POS || o_grad_qw == qpg_pkg::SAT_NEG))
        else $error("saturation flagged but no gradient sits at a bound");

endmodule
